// File: rtl/mmcd_pkg.sv
// Shared widths, codes and control types of the min/max column decimator.
`timescale 1ns / 1ps

package mmcd_pkg;

   // Widths of the sample index and of the window registers.
   localparam int INDEX_W = 32;
   // Width of the plot width register; the column quotient never exceeds it.
   localparam int WIDTH_W = 11;
   localparam int QUOT_W = WIDTH_W;
   // Offset times plot width.
   localparam int PRODUCT_W = INDEX_W + WIDTH_W;
   // Step counter of the divider, counts 0 .. QUOT_W-1.
   localparam int DIV_CNT_W = 4;
   // Column index wide enough for the largest supported column count.
   localparam int COL_IDX_W = 14;

   // Request kinds carried in tuser.
   localparam logic [1:0] REQ_UPDATE = 2'd0;
   localparam logic [1:0] REQ_READ = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   // Control of the column store for one cycle.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic wr_codes;
      logic wr_flag;
   } mmcd_store_ctl_type;

   // Status of the divider.
   typedef struct packed {
      logic busy;
      logic done;
   } mmcd_div_status_type;

endpackage

// File: rtl/mmcd_divider.sv
// Radix-2 restoring divider that turns the scaled offset into a column number.
`timescale 1ns / 1ps

module mmcd_divider
   import mmcd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [PRODUCT_W-1:0]     dividend,
   input  logic [INDEX_W-1:0]       divisor,
   output mmcd_div_status_type      status,
   output logic [QUOT_W-1:0]        quotient
);

   // The dividend is below divisor * 2**QUOT_W, so its upper part already lies
   // below the divisor and only QUOT_W quotient bits remain to be found.
   logic [INDEX_W-1:0]   rem_ff, rem_in;
   logic [QUOT_W-1:0]    quo_ff, quo_in;
   logic [INDEX_W-1:0]   div_ff, div_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [INDEX_W:0]     trial;
   logic [INDEX_W:0]     trial_diff;
   logic                 fits;

   // One shift and subtract step per cycle.
   always_comb begin
      trial = {rem_ff, quo_ff[QUOT_W-1]};
      trial_diff = trial - {1'b0, div_ff};
      fits = (trial >= {1'b0, div_ff});

      rem_in = rem_ff;
      quo_in = quo_ff;
      div_in = div_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         rem_in = dividend[PRODUCT_W-1:QUOT_W];
         quo_in = dividend[QUOT_W-1:0];
         div_in = divisor;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? trial_diff[INDEX_W-1:0] : trial[INDEX_W-1:0];
         quo_in = {quo_ff[QUOT_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(QUOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/mmcd_column_store.sv
// Per-column populated flags and low/high code memories with registered reads.
`timescale 1ns / 1ps

module mmcd_column_store
   import mmcd_pkg::*;
#(
   parameter int MAX_COLUMNS = 1024,
   parameter int CODE_BITS = 16,
   parameter int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
)(
   input  logic                  clock,
   input  mmcd_store_ctl_type    ctl,
   input  logic [COL_W-1:0]      rd_addr,
   input  logic [COL_W-1:0]      wr_addr,
   input  logic [CODE_BITS-1:0]  wr_low,
   input  logic [CODE_BITS-1:0]  wr_high,
   output logic                  rd_flag,
   output logic [CODE_BITS-1:0]  rd_low,
   output logic [CODE_BITS-1:0]  rd_high
);

   logic                 flag_mem_ff [MAX_COLUMNS];
   logic [CODE_BITS-1:0] low_mem_ff [MAX_COLUMNS];
   logic [CODE_BITS-1:0] high_mem_ff [MAX_COLUMNS];

   logic                 rd_flag_ff;
   logic [CODE_BITS-1:0] rd_low_ff;
   logic [CODE_BITS-1:0] rd_high_ff;

   // Flag writes come from updates and from the clearing sweep; the codes
   // are written only by updates.
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         flag_mem_ff[wr_addr] <= ctl.wr_flag;
         if (ctl.wr_codes) begin
            low_mem_ff[wr_addr] <= wr_low;
            high_mem_ff[wr_addr] <= wr_high;
         end
      end
   end

   // Registered read; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_flag_ff <= flag_mem_ff[rd_addr];
         rd_low_ff <= low_mem_ff[rd_addr];
         rd_high_ff <= high_mem_ff[rd_addr];
      end
   end

   assign rd_flag = rd_flag_ff;
   assign rd_low = rd_low_ff;
   assign rd_high = rd_high_ff;

endmodule

// File: rtl/min_max_column_decimator_top.sv
// Top level of the min/max column decimator: register port, sequencer and result register.
`timescale 1ns / 1ps

// The request channel carries sample updates, column reads and clear-all
// requests, selected by req_tuser. A sample whose index falls in the plot
// window is mapped to column floor((index - start) * width / span) and widens
// that column's low and high code. A read returns one item on the response
// channel: the populated flag in rsp_tuser and the low and high codes in
// rsp_tdata, all zero for an empty column. Updates and clears give no item.
// The block takes one request at a time. An update that lands in a column
// spends most of its time in the 11 steps of the shared shift-subtract
// divider; a sample that fails the window checks returns to idle before the
// divider starts, and one whose column lies beyond the store after it ends.
// A read's response comes through the registered store read. A clear sweeps
// the flag memory one column a cycle over all MAX_COLUMNS columns. After
// reset the same sweep runs before req_tready rises; register writes are
// taken throughout. The response sits in an output register, so a stalled
// receiver does not hold up updates or clears; only a read that finds the
// register still full waits for it to be taken. Registers are to be written
// only while the block is idle, a rule for the user the block does not enforce.

module min_max_column_decimator_top
   import mmcd_pkg::*;
#(
   parameter int MAX_COLUMNS = 1024,
   parameter int CODE_BITS = 16
)(
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // sample_position[31:0], sample_code[47:32],
                                    // read_column[57:48], zeros above
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // column_low[15:0], column_high[31:16]
   output logic        rsp_tuser,   // column_populated[0]
   // Register port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(MAX_COLUMNS - 1);

   // Register indexes.
   localparam logic [1:0] REG_START = 2'd0;
   localparam logic [1:0] REG_SPAN = 2'd1;
   localparam logic [1:0] REG_WIDTH = 2'd2;
   localparam logic [1:0] REG_AVAIL = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLEAR,
      S_CHECK,
      S_MUL,
      S_DIVGO,
      S_DIV,
      S_FETCH,
      S_MERGE,
      S_RDCOL,
      S_RDWAIT
   } state_type;

   state_type            state_ff, state_in;

   // Configuration registers.
   logic [INDEX_W-1:0]   start_ff, start_in;
   logic [INDEX_W-1:0]   span_ff, span_in;
   logic [WIDTH_W-1:0]   width_ff, width_in;
   logic [INDEX_W-1:0]   avail_ff, avail_in;

   // Current request and intermediate results.
   logic [INDEX_W-1:0]   idx_ff, idx_in;
   logic [CODE_BITS-1:0] code_ff, code_in;
   logic [9:0]           rc_ff, rc_in;
   logic [INDEX_W-1:0]   offset_ff, offset_in;
   logic                 below_ff, below_in;
   logic                 avail_ok_ff, avail_ok_in;
   logic [PRODUCT_W-1:0] product_ff, product_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [COL_W-1:0]     clr_cnt_ff, clr_cnt_in;
   logic                 rd_in_range_ff, rd_in_range_in;

   // Response register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_pop_ff, rsp_pop_in;
   logic [CODE_BITS-1:0] rsp_low_ff, rsp_low_in;
   logic [CODE_BITS-1:0] rsp_high_ff, rsp_high_in;

   logic                 req_accept;
   logic                 csr_write;
   logic [INDEX_W:0]     start_diff;
   logic [COL_IDX_W-1:0] quot_ext;
   logic [COL_IDX_W-1:0] rc_ext;

   mmcd_store_ctl_type   store_ctl;
   logic [COL_W-1:0]     st_rd_addr;
   logic [COL_W-1:0]     st_wr_addr;
   logic [CODE_BITS-1:0] st_wr_low;
   logic [CODE_BITS-1:0] st_wr_high;
   logic                 st_rd_flag;
   logic [CODE_BITS-1:0] st_rd_low;
   logic [CODE_BITS-1:0] st_rd_high;

   logic                 div_start;
   mmcd_div_status_type  div_status;
   logic [QUOT_W-1:0]    div_quot;

   mmcd_column_store #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .CODE_BITS   (CODE_BITS),
      .COL_W       (COL_W)
   ) u_store (
      .clock   (clock),
      .ctl     (store_ctl),
      .rd_addr (st_rd_addr),
      .wr_addr (st_wr_addr),
      .wr_low  (st_wr_low),
      .wr_high (st_wr_high),
      .rd_flag (st_rd_flag),
      .rd_low  (st_rd_low),
      .rd_high (st_rd_high)
   );

   mmcd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product_ff),
      .divisor  (span_ff),
      .status   (div_status),
      .quotient (div_quot)
   );

   assign req_accept = req_tvalid && req_tready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign start_diff = {1'b0, idx_ff} - {1'b0, start_ff};
   assign quot_ext = COL_IDX_W'(div_quot);
   assign rc_ext = COL_IDX_W'(rc_ff);

   // Sequencer, register writes and response register.
   always_comb begin
      state_in = state_ff;
      start_in = start_ff;
      span_in = span_ff;
      width_in = width_ff;
      avail_in = avail_ff;
      idx_in = idx_ff;
      code_in = code_ff;
      rc_in = rc_ff;
      offset_in = offset_ff;
      below_in = below_ff;
      avail_ok_in = avail_ok_ff;
      product_in = product_ff;
      col_in = col_ff;
      clr_cnt_in = clr_cnt_ff;
      rd_in_range_in = rd_in_range_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pop_in = rsp_pop_ff;
      rsp_low_in = rsp_low_ff;
      rsp_high_in = rsp_high_ff;

      store_ctl = '0;
      st_rd_addr = col_ff;
      st_wr_addr = col_ff;
      st_wr_low = code_ff;
      st_wr_high = code_ff;
      div_start = 1'b0;

      // Register writes.
      if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_START: start_in = csr_pwdata;
            REG_SPAN:  span_in = csr_pwdata;
            REG_WIDTH: width_in = csr_pwdata[WIDTH_W-1:0];
            REG_AVAIL: avail_in = csr_pwdata;
         endcase
      end

      // A taken response frees the output register.
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               idx_in = req_tdata[31:0];
               code_in = req_tdata[32 +: CODE_BITS];
               rc_in = req_tdata[57:48];
               unique case (req_tuser)
                  REQ_UPDATE: state_in = S_CHECK;
                  REQ_READ:   state_in = S_RDCOL;
                  REQ_CLEAR: begin
                     clr_cnt_in = '0;
                     state_in = S_CLEAR;
                  end
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_CLEAR: begin
            store_ctl.wr_en = 1'b1;
            store_ctl.wr_flag = 1'b0;
            st_wr_addr = clr_cnt_ff;
            if (clr_cnt_ff == LAST_COL) begin
               clr_cnt_in = '0;
               state_in = S_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         S_CHECK: begin
            offset_in = start_diff[INDEX_W-1:0];
            below_in = start_diff[INDEX_W];
            avail_ok_in = (idx_ff < avail_ff);
            state_in = S_MUL;
         end
         S_MUL: begin
            if ((span_ff == '0) || (width_ff == '0) || below_ff || !avail_ok_ff ||
                (offset_ff >= span_ff)) begin
               state_in = S_IDLE;
            end else begin
               product_in = offset_ff * width_ff;
               state_in = S_DIVGO;
            end
         end
         S_DIVGO: begin
            div_start = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_status.done) begin
               if ((div_quot < width_ff) && (32'(div_quot) < 32'(MAX_COLUMNS))) begin
                  col_in = quot_ext[COL_W-1:0];
                  state_in = S_FETCH;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_FETCH: begin
            store_ctl.rd_en = 1'b1;
            st_rd_addr = col_ff;
            state_in = S_MERGE;
         end
         S_MERGE: begin
            // An empty column takes the code as both bounds.
            store_ctl.wr_en = 1'b1;
            store_ctl.wr_codes = 1'b1;
            store_ctl.wr_flag = 1'b1;
            st_wr_low = (!st_rd_flag || (code_ff < st_rd_low)) ? code_ff : st_rd_low;
            st_wr_high = (!st_rd_flag || (code_ff > st_rd_high)) ? code_ff : st_rd_high;
            state_in = S_IDLE;
         end
         S_RDCOL: begin
            rd_in_range_in = (32'(rc_ff) < 32'(MAX_COLUMNS));
            store_ctl.rd_en = rd_in_range_in;
            st_rd_addr = rc_ext[COL_W-1:0];
            state_in = S_RDWAIT;
         end
         S_RDWAIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_pop_in = rd_in_range_ff && st_rd_flag;
               rsp_low_in = rsp_pop_in ? st_rd_low : '0;
               rsp_high_in = rsp_pop_in ? st_rd_high : '0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         start_ff <= '0;
         span_ff <= '0;
         width_ff <= '0;
         avail_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         start_ff <= start_in;
         span_ff <= span_in;
         width_ff <= width_in;
         avail_ff <= avail_in;
      end
      idx_ff <= idx_in;
      code_ff <= code_in;
      rc_ff <= rc_in;
      offset_ff <= offset_in;
      below_ff <= below_in;
      avail_ok_ff <= avail_ok_in;
      product_ff <= product_in;
      col_ff <= col_in;
      rd_in_range_ff <= rd_in_range_in;
      rsp_pop_ff <= rsp_pop_in;
      rsp_low_ff <= rsp_low_in;
      rsp_high_ff <= rsp_high_in;
   end

   // Register read back.
   always_comb begin
      unique case (csr_paddr[3:2])
         REG_START: csr_prdata = start_ff;
         REG_SPAN:  csr_prdata = span_ff;
         REG_WIDTH: csr_prdata = 32'(width_ff);
         REG_AVAIL: csr_prdata = avail_ff;
      endcase
   end

   assign csr_pready = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = rsp_pop_ff;
   assign rsp_tdata = {16'(rsp_high_ff), 16'(rsp_low_ff)};

   // An empty column reports zero codes.
   a_empty_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("empty column response carries nonzero codes");

   // A merged column never has its low bound above its high bound.
   a_merge_ordered: assert property (@(posedge clock) disable iff (reset)
      (store_ctl.wr_en && store_ctl.wr_codes) |-> (st_wr_low <= st_wr_high))
      else $error("column low bound written above high bound");

   // A clear request starts the sweep at the first column.
   a_clear_starts: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_tuser == REQ_CLEAR)) |=>
      ((state_ff == S_CLEAR) && (clr_cnt_ff == '0)))
      else $error("clear request did not start the sweep at column zero");

   // The divider finishes only while the sequencer waits for it.
   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == S_DIV))
      else $error("divider result arrived outside the divide state");

   // The divider works only while the sequencer waits for it.
   a_div_busy_waited: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> (state_ff == S_DIV))
      else $error("divider busy outside the divide state");

endmodule

// File: test/tb_top.sv
// Self-checking testbench of the min/max column decimator: stream stimulus and column predictor.
`timescale 1ns / 1ps

module tb_top
   import mmcd_pkg::*;
();

   localparam int MAX_COLUMNS = 1024;
   localparam int CODE_BITS = 16;
   localparam logic [15:0] CODE_MASK = 16'((32'd1 << CODE_BITS) - 1);

   // Request kind that the block ignores.
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // Register byte addresses.
   localparam logic [3:0] CSR_WINDOW_START = 4'h0;
   localparam logic [3:0] CSR_WINDOW_SPAN = 4'h4;
   localparam logic [3:0] CSR_PLOT_WIDTH = 4'h8;
   localparam logic [3:0] CSR_SAMPLES_AVAIL = 4'hC;

   // A clear sweeps every column, so this covers the longest silent job.
   localparam int QUIET_CYCLES = 1100;
   // Cycles with work pending and no handshake before the run is abandoned.
   localparam int STALL_LIMIT = 20000;
   localparam int PHASE_ITEMS = 150;
   localparam int RANDOM_PHASES = 9;

   typedef struct {
      logic [1:0]  kind;
      logic [31:0] index;
      logic [15:0] code;
      logic [9:0]  column;
   } request_item_type;

   typedef struct packed {
      logic        populated;
      logic [15:0] low;
      logic [15:0] high;
   } column_report_type;

   // Block ports.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;    // sample_position[31:0], sample_code[47:32],
                                   // read_column[57:48], zeros above
   logic [1:0]  req_tuser = '0;    // req_type[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // column_low[15:0], column_high[31:16]
   logic        rsp_tuser;         // column_populated[0]
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Predicted register contents and column store.
   logic [31:0] cfg_start = '0;
   logic [31:0] cfg_span = '0;
   logic [10:0] cfg_width = '0;
   logic [31:0] cfg_avail = '0;
   logic [15:0] column_min_mem [MAX_COLUMNS];
   logic [15:0] column_max_mem [MAX_COLUMNS];
   logic        column_filled [MAX_COLUMNS];

   request_item_type  request_q [$];
   column_report_type pending_reports [$];
   request_item_type  next_item;

   int          req_sent = 0;
   int          req_accepted = 0;
   int          reports_seen = 0;
   int          mismatches = 0;
   int          stall_cycles = 0;
   logic [9:0]  recent_column = '0;

   // Sender and receiver pacing.
   int          burst_left = 1;
   int          gap_left = 0;
   int          hold_left = 0;
   bit          holdoff_done = 1'b0;
   int          ready_mode = 0;
   int          mode_left = 0;

   min_max_column_decimator_top #(
      .MAX_COLUMNS(MAX_COLUMNS),
      .CODE_BITS(CODE_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #2 clock = ~clock;

   initial begin
      for (int i = 0; i < MAX_COLUMNS; i++) begin
         column_min_mem[i] = '0;
         column_max_mem[i] = '0;
         column_filled[i] = 1'b0;
      end
   end

   // Maps a sample index onto a column under the current window; returns 0 if skipped.
   function automatic bit map_column(input logic [31:0] index, output logic [9:0] column);
      logic [63:0] offset;
      logic [63:0] quotient;
      column = '0;
      if (cfg_span == 0 || cfg_width == 0) return 1'b0;
      if (index < cfg_start) return 1'b0;
      // The window end is compared in 64 bits so that it never wraps.
      offset = {32'd0, index} - {32'd0, cfg_start};
      if (offset >= {32'd0, cfg_span}) return 1'b0;
      if (index >= cfg_avail) return 1'b0;
      quotient = (offset * {53'd0, cfg_width}) / {32'd0, cfg_span};
      if (quotient >= {53'd0, cfg_width} || quotient >= MAX_COLUMNS) return 1'b0;
      column = quotient[9:0];
      return 1'b1;
   endfunction

   // Applies one accepted item to the predicted store.
   function automatic void apply_column_request(input request_item_type item);
      logic [9:0]        column;
      logic [15:0]       code;
      column_report_type report;
      code = item.code & CODE_MASK;
      case (item.kind)
         REQ_UPDATE: begin
            if (map_column(item.index, column)) begin
               if (!column_filled[column]) begin
                  column_filled[column] = 1'b1;
                  column_min_mem[column] = code;
                  column_max_mem[column] = code;
               end else begin
                  if (code < column_min_mem[column]) column_min_mem[column] = code;
                  if (code > column_max_mem[column]) column_max_mem[column] = code;
               end
            end
         end
         REQ_READ: begin
            report = '0;
            if (column_filled[item.column]) begin
               report.populated = 1'b1;
               report.low = column_min_mem[item.column];
               report.high = column_max_mem[item.column];
            end
            pending_reports.push_back(report);
         end
         REQ_CLEAR: begin
            for (int i = 0; i < MAX_COLUMNS; i++) column_filled[i] = 1'b0;
         end
         default: begin
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR at %0t ns: %s: got %h, expected %h", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic push_request(input logic [1:0] kind, input logic [31:0] index,
                               input logic [15:0] code, input logic [9:0] column);
      request_item_type item;
      item.kind = kind;
      item.index = index;
      item.code = code;
      item.column = column;
      request_q.push_back(item);
   endtask

   // Builds one random item, mostly samples that land inside the window.
   function automatic request_item_type random_request();
      request_item_type item;
      int               roll;
      logic [31:0]      reach;
      logic [9:0]       column;
      roll = $urandom_range(0, 99);
      item.kind = REQ_UPDATE;
      item.index = $urandom;
      item.code = 16'($urandom);
      item.column = 10'($urandom);
      if (roll < 60) begin
         if (cfg_span != 0) begin
            reach = cfg_span;
            if (cfg_avail > cfg_start && cfg_avail - cfg_start < reach)
               reach = cfg_avail - cfg_start;
            item.index = cfg_start + ($urandom % reach);
         end
         if (map_column(item.index, column)) recent_column = column;
      end else if (roll < 68) begin
         item.kind = REQ_UPDATE;
      end else if (roll < 94) begin
         item.kind = REQ_READ;
         if ($urandom_range(0, 1) == 0)
            item.column = recent_column;
         else if (cfg_width != 0 && cfg_width <= MAX_COLUMNS)
            item.column = 10'($urandom % cfg_width);
      end else if (roll < 97) begin
         item.kind = REQ_UNUSED;
      end else begin
         item.kind = REQ_CLEAR;
      end
      return item;
   endfunction

   // One register write: setup cycle, then access cycle.
   task automatic csr_write(input logic [3:0] addr, input logic [31:0] data);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (addr)
         CSR_WINDOW_START:  cfg_start = data;
         CSR_WINDOW_SPAN:   cfg_span = data;
         CSR_PLOT_WIDTH:    cfg_width = data[10:0];
         CSR_SAMPLES_AVAIL: cfg_avail = data;
         default: begin
         end
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_window(input logic [31:0] start, input logic [31:0] span,
                             input logic [31:0] width, input logic [31:0] avail);
      csr_write(CSR_WINDOW_START, start);
      csr_write(CSR_WINDOW_SPAN, span);
      csr_write(CSR_PLOT_WIDTH, width);
      csr_write(CSR_SAMPLES_AVAIL, avail);
   endtask

   // Waits until every item is taken and every read answered, then lets the block settle.
   task automatic wait_drained();
      while (request_q.size() != 0 || req_sent != req_accepted || pending_reports.size() != 0)
         @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // Request driver: bursts of items with random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && req_sent != req_accepted) begin
         // Hold the offered item until it is taken.
      end else if (gap_left > 0) begin
         gap_left <= gap_left - 1;
         req_tvalid <= 1'b0;
      end else if (request_q.size() != 0) begin
         next_item = request_q.pop_front();
         req_tdata <= {6'd0, next_item.column, next_item.code, next_item.index};
         req_tuser <= next_item.kind;
         req_tvalid <= 1'b1;
         req_sent <= req_sent + 1;
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Response receiver: changing stall patterns and one long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!holdoff_done && reports_seen >= 40) begin
         holdoff_done <= 1'b1;
         hold_left <= 600;
         rsp_tready <= 1'b0;
      end else if (mode_left == 0) begin
         ready_mode <= $urandom_range(0, 2);
         mode_left <= $urandom_range(20, 200);
         rsp_tready <= 1'b1;
      end else begin
         mode_left <= mode_left - 1;
         case (ready_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= ($urandom_range(0, 1) == 0);
            default: rsp_tready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   // Monitor: predicts accepted items, checks results, watches for a hang.
   always @(posedge clock) begin
      request_item_type  taken;
      column_report_type want;
      bit                busy;
      bit                moved;
      if (!reset) begin
         moved = 1'b0;
         busy = request_q.size() != 0 || req_sent != req_accepted ||
                pending_reports.size() != 0;
         if (req_tvalid && req_tready) begin
            taken.kind = req_tuser;
            taken.index = req_tdata[31:0];
            taken.code = req_tdata[47:32];
            taken.column = req_tdata[57:48];
            apply_column_request(taken);
            req_accepted = req_accepted + 1;
            moved = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            reports_seen = reports_seen + 1;
            if (pending_reports.size() == 0) begin
               report_mismatch("result with no read pending", rsp_tdata, 32'd0);
            end else begin
               want = pending_reports.pop_front();
               if (rsp_tuser !== want.populated)
                  report_mismatch("column_populated", {31'd0, rsp_tuser},
                                  {31'd0, want.populated});
               if (rsp_tdata[15:0] !== want.low)
                  report_mismatch("column_low", {16'd0, rsp_tdata[15:0]}, {16'd0, want.low});
               if (rsp_tdata[31:16] !== want.high)
                  report_mismatch("column_high", {16'd0, rsp_tdata[31:16]},
                                  {16'd0, want.high});
            end
         end
         if (busy && !moved) stall_cycles = stall_cycles + 1;
         else stall_cycles = 0;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("TIMEOUT after %0d cycles without progress", stall_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Stimulus sequence.
   initial begin
      logic [31:0] start;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Reset values: mapping disabled, so samples do nothing.
      push_request(REQ_UPDATE, 32'h0000_0000, 16'hFFFF, 10'd0);
      push_request(REQ_UPDATE, 32'hFFFF_FFFF, 16'h0000, 10'h3FF);
      push_request(REQ_READ, 32'd0, 16'd0, 10'd0);
      push_request(REQ_READ, 32'hFFFF_FFFF, 16'hFFFF, 10'h3FF);
      push_request(REQ_UNUSED, 32'd0, 16'd0, 10'd0);
      wait_drained();

      // Small window: below, inside, beyond the span and beyond the captured count.
      set_window(32'h10, 32'd32, 32'd16, 32'h28);
      push_request(REQ_UPDATE, 32'h0F, 16'h1111, 10'd0);
      push_request(REQ_UPDATE, 32'h10, 16'h8000, 10'd0);
      push_request(REQ_UPDATE, 32'h11, 16'hFFFF, 10'd0);
      push_request(REQ_UPDATE, 32'h11, 16'h0000, 10'd0);
      push_request(REQ_UPDATE, 32'h27, 16'h1234, 10'd0);
      push_request(REQ_UPDATE, 32'h2F, 16'h5555, 10'd0);
      push_request(REQ_UPDATE, 32'h30, 16'h6666, 10'd0);
      push_request(REQ_UPDATE, 32'hFFFF_FFFF, 16'h7777, 10'd0);
      push_request(REQ_READ, 32'd0, 16'd0, 10'd0);
      push_request(REQ_READ, 32'd0, 16'd0, 10'd11);
      push_request(REQ_READ, 32'd0, 16'd0, 10'd15);
      push_request(REQ_READ, 32'hFFFF_FFFF, 16'hFFFF, 10'h3FF);
      push_request(REQ_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 10'h3FF);
      push_request(REQ_CLEAR, 32'd0, 16'd0, 10'd0);
      push_request(REQ_READ, 32'd0, 16'd0, 10'd0);
      push_request(REQ_UPDATE, 32'h27, 16'h0042, 10'd0);
      push_request(REQ_READ, 32'd0, 16'd0, 10'd11);
      wait_drained();

      // Random phases over a spread of windows; columns carry over between them.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         start = $urandom;
         case (phase)
            0: set_window(32'd0, 32'd1024, 32'd1024, 32'hFFFF_FFFF);
            1: set_window(start, 32'd64, 32'd8, 32'hFFFF_FFFF);
            2: set_window(32'd0, 32'hFFFF_FFFF, 32'd1024, 32'hFFFF_FFFF);
            // Window end lies past the top of the index range.
            3: set_window(32'hFFFF_FF00, 32'hFFFF_FFFF, 32'd16, 32'hFFFF_FFFF);
            // More columns than the store holds; upper data bits are not stored.
            4: set_window(32'd1000, 32'd5000, 32'hFFFF_FFFF, 32'd4000);
            5: set_window(start, $urandom_range(1, 7), 32'd1, 32'hFFFF_FFFF);
            6: set_window(32'd0, 32'd100, 32'd0, 32'hFFFF_FFFF);
            7: set_window(32'd0, 32'd0, 32'd32, 32'hFFFF_FFFF);
            default: set_window(start, $urandom_range(1, 2000), $urandom_range(1, 1024),
                                start + $urandom_range(0, 3000));
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) request_q.push_back(random_request());
         wait_drained();
      end

      if (mismatches == 0 && pending_reports.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
